FILE: hdl/ppiio_pkg.sv
// Shared constants, codes, line map and types of the PPI I/O card.
`timescale 1ns / 1ps
`default_nettype none

package ppiio_pkg;

   // Line count defaults and the fixed number of lines that map to port bits.
   localparam int NUM_LINES_DEF = 12;
   localparam int MAPPED_LINES  = 12;

   // Register offsets on the bus.
   localparam logic [1:0] PORT_A    = 2'd0;
   localparam logic [1:0] PORT_B    = 2'd1;
   localparam logic [1:0] PORT_C    = 2'd2;
   localparam logic [1:0] PORT_CTRL = 2'd3;

   // Request commands.
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_PULSE = 2'd2;
   localparam logic [1:0] CMD_TICK  = 2'd3;

   // CSR indexes.
   localparam int          CSR_IDX_W       = 3;
   localparam int          CSR_DATA_W      = 13;
   localparam logic [2:0]  CSR_IDLE_A      = 3'd0;
   localparam logic [2:0]  CSR_IDLE_B      = 3'd1;
   localparam logic [2:0]  CSR_IDLE_C      = 3'd2;
   localparam logic [2:0]  CSR_PIN_A       = 3'd3;
   localparam logic [2:0]  CSR_PIN_B       = 3'd4;
   localparam logic [2:0]  CSR_PIN_C       = 3'd5;
   localparam logic [2:0]  CSR_HOLD_TICKS  = 3'd6;

   // Reset values of the CSRs.
   localparam logic [7:0]  IDLE_A_RST      = 8'hFF;
   localparam logic [7:0]  IDLE_B_RST      = 8'hFF;
   localparam logic [7:0]  IDLE_C_RST      = 8'hF0;
   localparam logic [7:0]  PIN_RST         = 8'h00;
   localparam logic [12:0] HOLD_TICKS_RST  = 13'd100;

   // Hold length limits.
   localparam logic [12:0] HOLD_MIN        = 13'd1;
   localparam logic [12:0] HOLD_MAX        = 13'd5000;

   localparam int          MODE_SET_BIT    = 7;
   localparam logic [7:0]  READ_IDLE       = 8'hFF;

   // Line map: lines 0..3 are C4..C7, 4/5 are A6/A7, 6/7 are A0/A1, 8..11 are C0..C3.
   localparam logic [1:0] LINE_PORT [MAPPED_LINES] = '{
      PORT_C, PORT_C, PORT_C, PORT_C, PORT_A, PORT_A,
      PORT_A, PORT_A, PORT_C, PORT_C, PORT_C, PORT_C
   };
   localparam logic [2:0] LINE_BIT [MAPPED_LINES] = '{
      3'd4, 3'd5, 3'd6, 3'd7, 3'd6, 3'd7, 3'd0, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3
   };

   typedef struct packed {
      logic [MAPPED_LINES-1:0] held;      // line currently driven asserted
      logic [MAPPED_LINES-1:0] released;  // line released since its port reloaded
   } line_status_type;

   function automatic logic [12:0] hold_len(input logic [12:0] ticks);
      logic [12:0] len;
      if (ticks < HOLD_MIN) begin
         len = HOLD_MIN;
      end else if (ticks > HOLD_MAX) begin
         len = HOLD_MAX;
      end else begin
         len = ticks;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/ppiio_ifs.sv
// Request and response channel interfaces of the PPI I/O card.
`timescale 1ns / 1ps
`default_nettype none

interface ppiio_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [1:0] reg_offset;
   logic [7:0] write_data;
   logic [3:0] line_index;

   modport source (output valid, command, reg_offset, write_data, line_index,
                   input ready);
   modport sink   (input valid, command, reg_offset, write_data, line_index,
                   output ready);
endinterface

interface ppiio_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [7:0]  latch_a;
   logic [7:0]  latch_b;
   logic [7:0]  latch_c;
   logic [11:0] held_lines;

   modport source (output valid, read_data, latch_a, latch_b, latch_c, held_lines,
                   input ready);
   modport sink   (input valid, read_data, latch_a, latch_b, latch_c, held_lines,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/ppi_io_card_with_line_hold_timers.sv
// Top level of the PPI I/O card: bus registers, input image, CSRs and response.
//
// Usage notes:
//  - req_bus carries one request per valid/ready handshake: a bus read, a bus
//    write, a line pulse or a timer tick. rsp_bus returns exactly one response
//    per request: the read byte (0xFF for the control register and for any
//    non-read), the three output latches and the held-line bitmap after the
//    request took effect.
//  - The response is registered: a request accepted at edge N shows its
//    response from edge N on. Throughput is one request per cycle unless
//    rsp_bus stalls. Each request needs one pass through decode and timers.
//  - The response register stalls only the request side: req_bus.ready is low
//    only while a response is held and rsp_bus.ready is low. The held
//    response, the latches and the hold counters stay frozen until it is taken.
//  - Reset (synchronous, active high) clears the latches and line timer flags,
//    loads the CSRs with their defaults (idle A/B 0xFF, idle C 0xF0, no pins,
//    hold 100 ticks) and empties the response register.
//  - The csr_ port writes one CSR per cycle with csr_we; index 7 is ignored.
//    An idle or pin write reloads that port's image; held lines stay asserted.
//  - The mode byte of a control write is not readable, so only its side
//    effect (clearing all latches) is kept.
`timescale 1ns / 1ps
`default_nettype none

module ppi_io_card_with_line_hold_timers #(
   parameter int NUM_LINES = ppiio_pkg::NUM_LINES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   ppiio_req_if.sink                             req_bus,
   ppiio_rsp_if.source                           rsp_bus,
   input  wire logic                             csr_we,
   input  wire logic [ppiio_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ppiio_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int ACTIVE_LINES = (NUM_LINES < ppiio_pkg::MAPPED_LINES) ?
                                 NUM_LINES : ppiio_pkg::MAPPED_LINES;

   // CSRs
   logic [7:0]  idle_a_ff, idle_b_ff, idle_c_ff;
   logic [7:0]  pin_a_ff, pin_b_ff, pin_c_ff;
   logic [12:0] hold_ticks_ff;

   // bus state
   logic [7:0]  latch_a_ff, latch_a_in;
   logic [7:0]  latch_b_ff, latch_b_in;
   logic [7:0]  latch_c_ff, latch_c_in;

   // response register
   logic        rsp_valid_ff;
   logic [7:0]  read_data_ff, read_data_in;

   logic        req_ready;
   logic        accept;
   logic        pulse;
   logic        tick;
   logic [7:0]  image_a, image_b, image_c;
   logic [ppiio_pkg::MAPPED_LINES-1:0] reload_mask;
   logic        reload_hit;
   logic [1:0]  reload_port;
   ppiio_pkg::line_status_type line_status;

   // response register is free or being emptied this cycle
   assign req_ready     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = req_ready;
   assign accept        = req_bus.valid && req_ready;

   assign pulse = accept && (req_bus.command == ppiio_pkg::CMD_PULSE) &&
                  (req_bus.line_index < 4'(ACTIVE_LINES));
   assign tick  = accept && (req_bus.command == ppiio_pkg::CMD_TICK);

   // Input image: unheld, unreleased bits read idle xor pin; held lines read
   // inverse idle; lines released since the last reload read idle.
   always_comb begin
      image_a = idle_a_ff ^ pin_a_ff;
      image_b = idle_b_ff ^ pin_b_ff;
      image_c = idle_c_ff ^ pin_c_ff;
      for (int i = 0; i < ACTIVE_LINES; i++) begin
         if (ppiio_pkg::LINE_PORT[i] == ppiio_pkg::PORT_A) begin
            if (line_status.held[i]) begin
               image_a[ppiio_pkg::LINE_BIT[i]] = ~idle_a_ff[ppiio_pkg::LINE_BIT[i]];
            end else if (line_status.released[i]) begin
               image_a[ppiio_pkg::LINE_BIT[i]] = idle_a_ff[ppiio_pkg::LINE_BIT[i]];
            end
         end else begin
            if (line_status.held[i]) begin
               image_c[ppiio_pkg::LINE_BIT[i]] = ~idle_c_ff[ppiio_pkg::LINE_BIT[i]];
            end else if (line_status.released[i]) begin
               image_c[ppiio_pkg::LINE_BIT[i]] = idle_c_ff[ppiio_pkg::LINE_BIT[i]];
            end
         end
      end
   end

   // Bus decode: read data and latch updates.
   always_comb begin
      read_data_in = ppiio_pkg::READ_IDLE;
      latch_a_in   = latch_a_ff;
      latch_b_in   = latch_b_ff;
      latch_c_in   = latch_c_ff;
      if (req_bus.command == ppiio_pkg::CMD_READ) begin
         unique case (req_bus.reg_offset)
            ppiio_pkg::PORT_A:    read_data_in = image_a;
            ppiio_pkg::PORT_B:    read_data_in = image_b;
            ppiio_pkg::PORT_C:    read_data_in = image_c;
            ppiio_pkg::PORT_CTRL: read_data_in = ppiio_pkg::READ_IDLE;
         endcase
      end
      if (accept && (req_bus.command == ppiio_pkg::CMD_WRITE)) begin
         unique case (req_bus.reg_offset)
            ppiio_pkg::PORT_A: latch_a_in = req_bus.write_data;
            ppiio_pkg::PORT_B: latch_b_in = req_bus.write_data;
            ppiio_pkg::PORT_C: latch_c_in = req_bus.write_data;
            ppiio_pkg::PORT_CTRL: begin
               if (req_bus.write_data[ppiio_pkg::MODE_SET_BIT]) begin
                  // mode set clears every latch
                  latch_a_in = '0;
                  latch_b_in = '0;
                  latch_c_in = '0;
               end else begin
                  // port C bit set/reset
                  latch_c_in[req_bus.write_data[3:1]] = req_bus.write_data[0];
               end
            end
         endcase
      end
   end

   // Which port an idle or pin CSR write reloads.
   always_comb begin
      reload_hit  = 1'b0;
      reload_port = ppiio_pkg::PORT_A;
      unique case (csr_index)
         ppiio_pkg::CSR_IDLE_A, ppiio_pkg::CSR_PIN_A: begin
            reload_hit  = csr_we;
            reload_port = ppiio_pkg::PORT_A;
         end
         ppiio_pkg::CSR_IDLE_B, ppiio_pkg::CSR_PIN_B: begin
            reload_hit  = csr_we;
            reload_port = ppiio_pkg::PORT_B;
         end
         ppiio_pkg::CSR_IDLE_C, ppiio_pkg::CSR_PIN_C: begin
            reload_hit  = csr_we;
            reload_port = ppiio_pkg::PORT_C;
         end
         default: begin
            reload_hit  = 1'b0;
            reload_port = ppiio_pkg::PORT_A;
         end
      endcase
      for (int i = 0; i < ppiio_pkg::MAPPED_LINES; i++) begin
         reload_mask[i] = reload_hit && (ppiio_pkg::LINE_PORT[i] == reload_port);
      end
   end

   ppiio_line_timers #(
      .NUM_LINES (NUM_LINES)
   ) u_timers (
      .clock       (clock),
      .reset       (reset),
      .pulse       (pulse),
      .pulse_line  (req_bus.line_index),
      .tick        (tick),
      .hold_len    (ppiio_pkg::hold_len(hold_ticks_ff)),
      .reload_mask (reload_mask),
      .status      (line_status)
   );

   // CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_a_ff     <= ppiio_pkg::IDLE_A_RST;
         idle_b_ff     <= ppiio_pkg::IDLE_B_RST;
         idle_c_ff     <= ppiio_pkg::IDLE_C_RST;
         pin_a_ff      <= ppiio_pkg::PIN_RST;
         pin_b_ff      <= ppiio_pkg::PIN_RST;
         pin_c_ff      <= ppiio_pkg::PIN_RST;
         hold_ticks_ff <= ppiio_pkg::HOLD_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ppiio_pkg::CSR_IDLE_A:     idle_a_ff     <= csr_wdata[7:0];
            ppiio_pkg::CSR_IDLE_B:     idle_b_ff     <= csr_wdata[7:0];
            ppiio_pkg::CSR_IDLE_C:     idle_c_ff     <= csr_wdata[7:0];
            ppiio_pkg::CSR_PIN_A:      pin_a_ff      <= csr_wdata[7:0];
            ppiio_pkg::CSR_PIN_B:      pin_b_ff      <= csr_wdata[7:0];
            ppiio_pkg::CSR_PIN_C:      pin_c_ff      <= csr_wdata[7:0];
            ppiio_pkg::CSR_HOLD_TICKS: hold_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Latches and response. Latch and held-line state only change on an accepted
   // request, so the response shows them straight from their registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         latch_a_ff   <= '0;
         latch_b_ff   <= '0;
         latch_c_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         latch_a_ff <= latch_a_in;
         latch_b_ff <= latch_b_in;
         latch_c_ff <= latch_c_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff <= read_data_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_data  = read_data_ff;
   assign rsp_bus.latch_a    = latch_a_ff;
   assign rsp_bus.latch_b    = latch_b_ff;
   assign rsp_bus.latch_c    = latch_c_ff;
   assign rsp_bus.held_lines = line_status.held;

endmodule

`default_nettype wire

FILE: hdl/ppiio_line_timers.sv
// Per-line hold counters with held and released flags.
`timescale 1ns / 1ps
`default_nettype none

module ppiio_line_timers #(
   parameter int NUM_LINES = ppiio_pkg::NUM_LINES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               pulse,
   input  wire logic [3:0]                         pulse_line,
   input  wire logic                               tick,
   input  wire logic [12:0]                        hold_len,
   input  wire logic [ppiio_pkg::MAPPED_LINES-1:0] reload_mask,
   output ppiio_pkg::line_status_type              status
);

   localparam int ACTIVE_LINES = (NUM_LINES < ppiio_pkg::MAPPED_LINES) ?
                                 NUM_LINES : ppiio_pkg::MAPPED_LINES;

   for (genvar i = 0; i < ppiio_pkg::MAPPED_LINES; i++) begin : g_line
      if (i < ACTIVE_LINES) begin : g_timer
         logic [12:0] count_ff, count_in;
         logic        held_ff, held_in;
         logic        rel_ff, rel_in;
         logic [12:0] count_dec;

         assign count_dec = count_ff - 13'd1;

         always_comb begin
            count_in = count_ff;
            held_in  = held_ff;
            rel_in   = rel_ff;
            if (pulse && (pulse_line == 4'(i))) begin
               count_in = hold_len;
               held_in  = 1'b1;
            end else if (tick && held_ff) begin
               // held counters are never zero, so the decrement is safe
               count_in = count_dec;
               if (count_dec == 13'd0) begin
                  held_in = 1'b0;
                  rel_in  = 1'b1;
               end
            end
            if (reload_mask[i]) begin
               rel_in = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            count_ff <= count_in;
            if (reset) begin
               held_ff <= 1'b0;
               rel_ff  <= 1'b0;
            end else begin
               held_ff <= held_in;
               rel_ff  <= rel_in;
            end
         end

         assign status.held[i]     = held_ff;
         assign status.released[i] = rel_ff;
      end else begin : g_unused
         assign status.held[i]     = 1'b0;
         assign status.released[i] = 1'b0;
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/ppi_io_card_with_line_hold_timers_test.sv
// Self-checking testbench for the PPI I/O card with pulse-stretched input lines.
`timescale 1ns / 1ps

module ppi_io_card_with_line_hold_timers_test;

   localparam int          CARD_LINES       = 12;
   localparam int          RESET_CYCLES     = 11;
   localparam int          QUIET_LIMIT      = 1000;  // cycles with no handshake at all
   localparam int          RANDOM_PHASES    = 9;
   localparam int          RANDOM_PER_PHASE = 150;
   localparam int          MAX_PRINTED      = 40;
   localparam int          MODE_BIT         = 7;
   localparam logic [2:0]  CSR_UNUSED       = 3'd7;  // index past the last register
   localparam logic [7:0]  BUS_FLOAT        = 8'hFF; // read of control or non-read
   localparam logic [12:0] HOLD_FLOOR       = 13'd1;
   localparam logic [12:0] HOLD_CEILING     = 13'd5000;

   typedef struct packed {
      logic [1:0] command;
      logic [1:0] reg_offset;
      logic [7:0] write_data;
      logic [3:0] line_index;
   } card_req_type;

   // What one response shows: the read byte plus the card's visible state.
   typedef struct packed {
      logic [7:0]  read_data;
      logic [7:0]  latch_a;
      logic [7:0]  latch_b;
      logic [7:0]  latch_c;
      logic [11:0] held_lines;
   } card_view_type;

   typedef struct packed {
      logic [1:0] port;
      logic [2:0] bitpos;
   } line_site_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_we;
   logic [ppiio_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ppiio_pkg::CSR_DATA_W-1:0] csr_wdata;

   ppiio_req_if req_bus ();
   ppiio_rsp_if rsp_bus ();

   ppi_io_card_with_line_hold_timers #(
      .NUM_LINES (CARD_LINES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Card model: own copy of the settings and of every piece of state.
   // ---------------------------------------------------------------------
   logic [7:0]  idle_level [3];
   logic [7:0]  pin_mask   [3];
   logic [12:0] hold_cfg;
   logic [7:0]  out_latch  [3];
   logic [7:0]  in_image   [3];
   logic [11:0] held_map;
   logic [12:0] hold_left  [CARD_LINES];

   // Stimulus and bookkeeping.
   card_req_type  bus_requests [$];   // requests not yet offered to the card
   card_view_type predicted_rsps [$]; // responses owed by the card, oldest first
   logic [12:0]   csr_plan [8];       // register values for the next phase
   int unsigned   queued_count;
   int unsigned   taken_count;        // requests accepted by the card so far
   int unsigned   mismatch_count;
   int unsigned   quiet_cycles;
   int unsigned   gap_left;
   int unsigned   stall_left;
   logic          req_taken;          // request handshake seen at the last rising edge
   bit            req_gaps_on;
   bit            rsp_stalls_on;

   // Lines 0..3 sit on C4..C7, 4/5 on A6/A7, 6/7 on A0/A1, 8..11 on C0..C3.
   function automatic line_site_type line_site(input logic [3:0] line);
      line_site_type s;
      case (line)
         4'd0, 4'd1, 4'd2, 4'd3: begin
            s.port   = ppiio_pkg::PORT_C;
            s.bitpos = line[2:0] + 3'd4;
         end
         4'd4, 4'd5: begin
            s.port   = ppiio_pkg::PORT_A;
            s.bitpos = line[2:0] + 3'd2;
         end
         4'd6, 4'd7: begin
            s.port   = ppiio_pkg::PORT_A;
            s.bitpos = line[2:0] - 3'd6;
         end
         default: begin
            s.port   = ppiio_pkg::PORT_C;
            s.bitpos = line[2:0];
         end
      endcase
      return s;
   endfunction

   // Asserted means the inverse of the port's current idle bit.
   task automatic drive_line(input logic [3:0] line, input logic asserted);
      line_site_type s;
      s = line_site(line);
      if (asserted) begin
         in_image[s.port][s.bitpos] = ~idle_level[s.port][s.bitpos];
      end else begin
         in_image[s.port][s.bitpos] = idle_level[s.port][s.bitpos];
      end
   endtask

   task automatic reload_port(input logic [1:0] port);
      line_site_type s;
      in_image[port] = idle_level[port] ^ pin_mask[port];
      for (int i = 0; i < CARD_LINES; i++) begin
         s = line_site(i[3:0]);
         if (held_map[i] && s.port == port) begin
            drive_line(i[3:0], 1'b1);
         end
      end
   endtask

   task automatic reset_card_model();
      idle_level[ppiio_pkg::PORT_A] = 8'hFF;
      idle_level[ppiio_pkg::PORT_B] = 8'hFF;
      idle_level[ppiio_pkg::PORT_C] = 8'hF0;
      hold_cfg = 13'd100;
      held_map = '0;
      for (int p = 0; p < 3; p++) begin
         pin_mask[p]  = 8'h00;
         out_latch[p] = 8'h00;
         in_image[p]  = idle_level[p];
      end
      for (int i = 0; i < CARD_LINES; i++) begin
         hold_left[i] = '0;
      end
   endtask

   task automatic apply_csr(input logic [2:0] index, input logic [12:0] data);
      case (index)
         ppiio_pkg::CSR_IDLE_A, ppiio_pkg::CSR_IDLE_B, ppiio_pkg::CSR_IDLE_C: begin
            idle_level[index[1:0]] = data[7:0];
            reload_port(index[1:0]);
         end
         ppiio_pkg::CSR_PIN_A, ppiio_pkg::CSR_PIN_B, ppiio_pkg::CSR_PIN_C: begin
            pin_mask[index - ppiio_pkg::CSR_PIN_A] = data[7:0];
            reload_port(2'(index - ppiio_pkg::CSR_PIN_A));
         end
         ppiio_pkg::CSR_HOLD_TICKS: hold_cfg = data;
         default: ;  // unused index: no effect
      endcase
   endtask

   // One request in, the view the card must show afterwards out.
   task automatic card_step(input card_req_type r, output card_view_type v);
      logic [7:0]  rd;
      logic [12:0] len;
      rd = BUS_FLOAT;
      if (hold_cfg < HOLD_FLOOR) begin
         len = HOLD_FLOOR;
      end else if (hold_cfg > HOLD_CEILING) begin
         len = HOLD_CEILING;
      end else begin
         len = hold_cfg;
      end
      case (r.command)
         ppiio_pkg::CMD_READ: begin
            if (r.reg_offset != ppiio_pkg::PORT_CTRL) rd = in_image[r.reg_offset];
         end
         ppiio_pkg::CMD_WRITE: begin
            if (r.reg_offset != ppiio_pkg::PORT_CTRL) begin
               out_latch[r.reg_offset] = r.write_data;
            end else if (r.write_data[MODE_BIT]) begin
               // mode set clears all three latches
               out_latch[ppiio_pkg::PORT_A] = 8'h00;
               out_latch[ppiio_pkg::PORT_B] = 8'h00;
               out_latch[ppiio_pkg::PORT_C] = 8'h00;
            end else begin
               // single bit set/reset on port C
               out_latch[ppiio_pkg::PORT_C][r.write_data[3:1]] = r.write_data[0];
            end
         end
         ppiio_pkg::CMD_PULSE: begin
            if (r.line_index < CARD_LINES) begin
               drive_line(r.line_index, 1'b1);
               held_map[r.line_index]  = 1'b1;
               hold_left[r.line_index] = len;
            end
         end
         default: begin  // tick
            for (int i = 0; i < CARD_LINES; i++) begin
               if (held_map[i]) begin
                  if (hold_left[i] != 0) hold_left[i] = hold_left[i] - 13'd1;
                  if (hold_left[i] == 0) begin
                     drive_line(i[3:0], 1'b0);
                     held_map[i] = 1'b0;
                  end
               end
            end
         end
      endcase
      v.read_data  = rd;
      v.latch_a    = out_latch[ppiio_pkg::PORT_A];
      v.latch_b    = out_latch[ppiio_pkg::PORT_B];
      v.latch_c    = out_latch[ppiio_pkg::PORT_C];
      v.held_lines = held_map;
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic flag_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [11:0] got,
                              input logic [11:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("%s is 0x%0h, want 0x%0h", name, got, want));
      end
   endtask

   // Everything is sampled at the rising edge. The response check runs before
   // the request is folded into the model, so a response is never matched
   // against a request taken at the same edge.
   always @(posedge clock) begin : monitor
      card_view_type got;
      card_view_type want;
      logic          progress;
      if (reset) begin
         reset_card_model();
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         progress = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            progress       = 1'b1;
            got.read_data  = rsp_bus.read_data;
            got.latch_a    = rsp_bus.latch_a;
            got.latch_b    = rsp_bus.latch_b;
            got.latch_c    = rsp_bus.latch_c;
            got.held_lines = rsp_bus.held_lines;
            if (predicted_rsps.size() == 0) begin
               flag_mismatch("response with no request outstanding");
            end else begin
               want = predicted_rsps.pop_front();
               check_field("read_data", 12'(got.read_data), 12'(want.read_data));
               check_field("latch_a", 12'(got.latch_a), 12'(want.latch_a));
               check_field("latch_b", 12'(got.latch_b), 12'(want.latch_b));
               check_field("latch_c", 12'(got.latch_c), 12'(want.latch_c));
               check_field("held_lines", got.held_lines, want.held_lines);
            end
         end
         if (csr_we) begin
            progress = 1'b1;
            apply_csr(csr_index, csr_wdata);
         end
         if (req_bus.valid && req_bus.ready) begin
            progress = 1'b1;
            card_step('{req_bus.command, req_bus.reg_offset, req_bus.write_data,
                        req_bus.line_index}, want);
            predicted_rsps.push_back(want);
            taken_count++;
         end
         req_taken    <= req_bus.valid && req_bus.ready;
         quiet_cycles <= progress ? 0 : quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Request driver and response back-pressure, both on the falling edge.
   // ---------------------------------------------------------------------
   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin : request_driver
      card_req_type r;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left      <= 0;
      end else if (req_bus.valid && !req_taken) begin
         // request still waiting for ready: hold it
      end else if (gap_left != 0) begin
         req_bus.valid <= 1'b0;
         gap_left      <= gap_left - 1;
      end else if (bus_requests.size() != 0) begin
         r = bus_requests.pop_front();
         req_bus.valid      <= 1'b1;
         req_bus.command    <= r.command;
         req_bus.reg_offset <= r.reg_offset;
         req_bus.write_data <= r.write_data;
         req_bus.line_index <= r.line_index;
         gap_left           <= pick_gap(req_gaps_on);
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin : response_stall
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (rsp_stalls_on && $urandom_range(0, 4) == 0) stall_left <= pick_gap(1'b1);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic queue_req(input logic [1:0] command, input logic [1:0] reg_offset,
                            input logic [7:0] write_data, input logic [3:0] line_index);
      card_req_type r;
      r.command    = command;
      r.reg_offset = reg_offset;
      r.write_data = write_data;
      r.line_index = line_index;
      bus_requests.push_back(r);
      queued_count++;
   endtask

   // Returns on a falling edge once every queued request has been taken and
   // answered, so nothing is in flight.
   task automatic wait_drained();
      do @(negedge clock);
      while (bus_requests.size() != 0 || taken_count != queued_count ||
             req_bus.valid || predicted_rsps.size() != 0);
   endtask

   // Writes csr_plan, one register per cycle, unused index included.
   task automatic load_settings();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= csr_plan[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Mostly pulse-then-tick-down sequences with reads and writes mixed in,
   // the rest fully random requests (out-of-range lines among them).
   task automatic queue_random(input int unsigned count);
      int unsigned target;
      target = queued_count + count;
      while (queued_count < target) begin
         if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(1, 3)) begin
               queue_req(ppiio_pkg::CMD_PULSE, 2'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)), 4'($urandom_range(0, CARD_LINES - 1)));
            end
            repeat ($urandom_range(1, 8)) begin
               queue_req(ppiio_pkg::CMD_TICK, 2'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
               case ($urandom_range(0, 3))
                  0: queue_req(ppiio_pkg::CMD_READ, ppiio_pkg::PORT_A,
                               8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
                  1: queue_req(ppiio_pkg::CMD_READ, ppiio_pkg::PORT_C,
                               8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
                  2: queue_req(ppiio_pkg::CMD_WRITE, 2'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
                  default: ;
               endcase
            end
         end else begin
            queue_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
         end
      end
   endtask

   // Watchdog: a stretch with no handshake of any kind ends the run.
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("ppi_io_card_with_line_hold_timers test failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase;
      req_bus.valid      = 1'b0;
      req_bus.command    = ppiio_pkg::CMD_READ;
      req_bus.reg_offset = ppiio_pkg::PORT_A;
      req_bus.write_data = 8'h00;
      req_bus.line_index = 4'd0;
      rsp_bus.ready      = 1'b0;
      csr_we             = 1'b0;
      csr_index          = ppiio_pkg::CSR_IDLE_A;
      csr_wdata          = '0;
      queued_count       = 0;
      taken_count        = 0;
      mismatch_count     = 0;
      req_gaps_on        = 1'b1;
      rsp_stalls_on      = 1'b1;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed requests on reset settings: reset images and control read,
      // latch writes at both extremes, port C bit set/reset, mode set
      // clearing the latches, pulses on both ports, out-of-range lines,
      // a re-pulse of a held line and ticks.
      queue_req(ppiio_pkg::CMD_READ, ppiio_pkg::PORT_A, 8'h00, 4'd0);
      queue_req(ppiio_pkg::CMD_READ, ppiio_pkg::PORT_B, 8'hFF, 4'd15);
      queue_req(ppiio_pkg::CMD_READ, ppiio_pkg::PORT_C, 8'h00, 4'd0);
      queue_req(ppiio_pkg::CMD_READ, ppiio_pkg::PORT_CTRL, 8'h00, 4'd0);
      queue_req(ppiio_pkg::CMD_WRITE, ppiio_pkg::PORT_A, 8'hFF, 4'd0);
      queue_req(ppiio_pkg::CMD_WRITE, ppiio_pkg::PORT_B, 8'h00, 4'd0);
      queue_req(ppiio_pkg::CMD_WRITE, ppiio_pkg::PORT_C, 8'h5A, 4'd0);
      queue_req(ppiio_pkg::CMD_WRITE, ppiio_pkg::PORT_CTRL, 8'h0F, 4'd0);  // set C7
      queue_req(ppiio_pkg::CMD_WRITE, ppiio_pkg::PORT_CTRL, 8'h08, 4'd0);  // clear C4
      queue_req(ppiio_pkg::CMD_WRITE, ppiio_pkg::PORT_CTRL, 8'h9B, 4'd0);  // mode set
      queue_req(ppiio_pkg::CMD_PULSE, ppiio_pkg::PORT_A, 8'h00, 4'd0);
      queue_req(ppiio_pkg::CMD_PULSE, ppiio_pkg::PORT_A, 8'h00, 4'd5);
      queue_req(ppiio_pkg::CMD_PULSE, ppiio_pkg::PORT_A, 8'h00, 4'd6);
      queue_req(ppiio_pkg::CMD_PULSE, ppiio_pkg::PORT_A, 8'h00, 4'd11);
      queue_req(ppiio_pkg::CMD_PULSE, ppiio_pkg::PORT_A, 8'h00, 4'd12);  // beyond the last line
      queue_req(ppiio_pkg::CMD_PULSE, ppiio_pkg::PORT_A, 8'h00, 4'd15);  // beyond the last line
      queue_req(ppiio_pkg::CMD_READ, ppiio_pkg::PORT_A, 8'h00, 4'd0);
      queue_req(ppiio_pkg::CMD_READ, ppiio_pkg::PORT_C, 8'h00, 4'd0);
      queue_req(ppiio_pkg::CMD_PULSE, ppiio_pkg::PORT_A, 8'h00, 4'd0);   // already held: restart
      queue_req(ppiio_pkg::CMD_TICK, ppiio_pkg::PORT_A, 8'h00, 4'd0);
      queue_req(ppiio_pkg::CMD_TICK, ppiio_pkg::PORT_A, 8'h00, 4'd0);
      queue_req(ppiio_pkg::CMD_READ, ppiio_pkg::PORT_A, 8'h00, 4'd0);
      queue_req(ppiio_pkg::CMD_READ, ppiio_pkg::PORT_C, 8'h00, 4'd0);
      wait_drained();

      // Random phases. Each one starts from an idle card, rewrites every
      // register (held lines carry over, so a reload meets asserted lines)
      // and runs with its own mix of sender gaps and receiver stalls.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               // all-low idle on A/B, all-high on C, zero hold saturating up
               csr_plan[ppiio_pkg::CSR_IDLE_A]     = 13'h0000;
               csr_plan[ppiio_pkg::CSR_IDLE_B]     = 13'h0000;
               csr_plan[ppiio_pkg::CSR_IDLE_C]     = 13'h00FF;
               csr_plan[ppiio_pkg::CSR_PIN_A]      = 13'h0000;
               csr_plan[ppiio_pkg::CSR_PIN_B]      = 13'h0000;
               csr_plan[ppiio_pkg::CSR_PIN_C]      = 13'h0000;
               csr_plan[ppiio_pkg::CSR_HOLD_TICKS] = 13'h0000;
            end
            1: begin
               // every bit set, hold above the ceiling
               for (int i = 0; i < 7; i++) csr_plan[i] = 13'h1FFF;
            end
            default: begin
               for (int i = 0; i < 6; i++) csr_plan[i] = 13'($urandom_range(0, 8191));
               if (phase == 2) begin
                  csr_plan[ppiio_pkg::CSR_HOLD_TICKS] = HOLD_FLOOR;
               end else if (phase == 4) begin
                  csr_plan[ppiio_pkg::CSR_HOLD_TICKS] = HOLD_CEILING;
               end else begin
                  csr_plan[ppiio_pkg::CSR_HOLD_TICKS] = 13'($urandom_range(2, 16));
               end
            end
         endcase
         csr_plan[CSR_UNUSED] = 13'($urandom_range(0, 8191));
         load_settings();
         req_gaps_on   = phase[0];
         rsp_stalls_on = phase[1];
         queue_random(RANDOM_PER_PHASE);
         wait_drained();
      end

      // Let any stray response show up before the verdict.
      repeat (4) @(negedge clock);
      if (predicted_rsps.size() != 0) flag_mismatch("responses still outstanding at the end");
      if (mismatch_count == 0) begin
         $display("ppi_io_card_with_line_hold_timers test passed");
      end else begin
         $display("ppi_io_card_with_line_hold_timers test failed");
      end
      $finish;
   end

endmodule

FILE: ppi_io_card_with_line_hold_timers.f
hdl/ppiio_pkg.sv
hdl/ppiio_ifs.sv
hdl/ppiio_line_timers.sv
hdl/ppi_io_card_with_line_hold_timers.sv
tb/sv/ppi_io_card_with_line_hold_timers_test.sv
